/* sv/ple_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared codes and types of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned DefCapacity  = 64;
  localparam int unsigned DefDataWidth = 32;

  // request operation codes
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_SET    = 3'd2,
    OP_GET    = 3'd3,
    OP_LOCATE = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_MISS   = 2'd3
  } status_e;

  // action a probe performs as it walks the cell chain
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_DELETE,
    ACT_SET,
    ACT_GET,
    ACT_LOCATE
  } act_e;

  // probe control carried from cell to cell
  typedef struct packed {
    logic valid;
    act_e act;
    logic hit;
  } probe_ctl_t;

endpackage

/* sv/ple_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_if
// Request and response channels of the positional list engine.
// ----------------------------------------------------------------------------
interface ple_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  op;
  logic        [6:0]  position;
  logic signed [31:0] value;

  modport source (output valid, output op, output position, output value, input ready);
  modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ple_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] data_out;
  logic        [5:0]  found_index;
  logic        [6:0]  count;

  modport source (output valid, output status, output data_out, output found_index,
                  output count, input ready);
  modport sink   (input valid, input status, input data_out, input found_index,
                  input count, output ready);
endinterface

/* sv/ple_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry and acts on the probe passing through it.
// ----------------------------------------------------------------------------
module ple_cell
  import ple_pkg::*;
#(
  parameter int unsigned IDX        = 0,
  parameter int unsigned IDX_W      = 6,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  probe_ctl_t            ctl_i,
  input  logic [IDX_W-1:0]      pos_i,
  input  logic [CNT_W-1:0]      cnt_i,
  input  logic [DATA_WIDTH-1:0] val_i,
  input  logic [DATA_WIDTH-1:0] carry_i,
  input  logic [IDX_W-1:0]      fidx_i,
  output probe_ctl_t            ctl_o,
  output logic [IDX_W-1:0]      pos_o,
  output logic [CNT_W-1:0]      cnt_o,
  output logic [DATA_WIDTH-1:0] val_o,
  output logic [DATA_WIDTH-1:0] carry_o,
  output logic [IDX_W-1:0]      fidx_o,
  // shift-down handoff from the right neighbor, and to the left one
  input  logic                  bk_valid_i,
  input  logic [DATA_WIDTH-1:0] bk_data_i,
  output logic                  bk_valid_o,
  output logic [DATA_WIDTH-1:0] bk_data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MyCnt = CNT_W'(IDX);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic [DATA_WIDTH-1:0] carry_d;
  logic [IDX_W-1:0]      fidx_d;
  logic                  hit_d;
  logic                  at_pos, above, below_cnt, upto_cnt;

  assign at_pos    = (pos_i == MyIdx);
  assign above     = (MyIdx > pos_i);
  assign below_cnt = (MyCnt < cnt_i);
  assign upto_cnt  = (MyCnt <= cnt_i);
  assign bk_data_o = entry_q;

  always_comb begin
    entry_d    = entry_q;
    carry_d    = carry_i;
    fidx_d     = fidx_i;
    hit_d      = ctl_i.hit;
    bk_valid_o = 1'b0;
    if (ctl_i.valid) begin
      unique case (ctl_i.act)
        ACT_NONE: begin
        end
        ACT_INSERT: begin
          if (at_pos) begin
            entry_d = val_i;
            carry_d = entry_q;
          end else if (above && upto_cnt) begin
            entry_d = carry_i;
            carry_d = entry_q;
          end
        end
        ACT_DELETE: begin
          if (at_pos) begin
            carry_d = entry_q;
          end else if (above && below_cnt) begin
            bk_valid_o = 1'b1;
          end
        end
        ACT_SET: begin
          if (at_pos) entry_d = val_i;
        end
        ACT_GET: begin
          if (at_pos) carry_d = entry_q;
        end
        ACT_LOCATE: begin
          if (!ctl_i.hit && below_cnt && (entry_q == val_i)) begin
            hit_d  = 1'b1;
            fidx_d = MyIdx;
          end
        end
        default: begin
        end
      endcase
    end
    // the right neighbor only hands down after this cell's probe has left
    if (bk_valid_i) entry_d = bk_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '{valid: 1'b0, act: ACT_NONE, hit: 1'b0};
    end else begin
      ctl_o <= '{valid: ctl_i.valid, act: ctl_i.act, hit: hit_d};
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    pos_o   <= pos_i;
    cnt_o   <= cnt_i;
    val_o   <= val_i;
    carry_o <= carry_d;
    fidx_o  <= fidx_d;
  end

endmodule

/* sv/positional_list_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Fixed-capacity ordered list with insert, delete, set, get and locate.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  req_i   | in  | valid/ready | op, position, value
//  rsp_o   | out | valid/ready | status, data_out, found_index, count
//
//  After its transfer, a request's probe enters a head register and walks
//  the row of CAPACITY cells, one cell a cycle, then lands in the output
//  register, where its result is valid.
//  One request is in flight at a time; the next one is taken once the result
//  register is free or being emptied in the same cycle.
//  Reset clears the count and all control; entries hold nothing meaningful
//  until written, and no read looks at a slot at or above the count.
//  A stalled response just holds the output register; the cells never stall.
// ----------------------------------------------------------------------------
module positional_list_engine_core
  import ple_pkg::*;
#(
  parameter int unsigned CAPACITY   = DefCapacity,
  parameter int unsigned DATA_WIDTH = DefDataWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ple_req_if.sink      req_i,
  ple_rsp_if.source    rsp_o
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_BUSY
  } state_e;

  state_e state_q;

  // running entry count and the status fixed at transfer time
  logic [CNT_W-1:0] count_q, count_d;
  status_e          status_q, status_d;
  act_e             act_d;

  // head of the probe chain
  probe_ctl_t            head_ctl_q;
  logic [IDX_W-1:0]      head_pos_q;
  logic [CNT_W-1:0]      head_cnt_q;
  logic [DATA_WIDTH-1:0] head_val_q;

  // output register
  logic             out_valid_q;
  status_e          out_status_q;
  logic [31:0]      out_data_q;
  logic [5:0]       out_fidx_q;
  logic [6:0]       out_count_q;

  logic             req_fire;
  logic [CMP_W-1:0] pos_ext, cnt_ext;

  // per-cell chain wiring; element i is the output of cell i
  probe_ctl_t            ch_ctl   [CAPACITY];
  logic [IDX_W-1:0]      ch_pos   [CAPACITY];
  logic [CNT_W-1:0]      ch_cnt   [CAPACITY];
  logic [DATA_WIDTH-1:0] ch_val   [CAPACITY];
  logic [DATA_WIDTH-1:0] ch_carry [CAPACITY];
  logic [IDX_W-1:0]      ch_fidx  [CAPACITY];
  logic                  bk_valid [CAPACITY];
  logic [DATA_WIDTH-1:0] bk_data  [CAPACITY];

  probe_ctl_t            tail_ctl;
  logic [DATA_WIDTH-1:0] tail_carry;
  logic [IDX_W-1:0]      tail_fidx;

  assign req_i.ready = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;

  assign pos_ext = CMP_W'(req_i.position);
  assign cnt_ext = CMP_W'(count_q);

  // legality checks need only the count, so they resolve at transfer time
  always_comb begin
    status_d = ST_OK;
    act_d    = ACT_NONE;
    count_d  = count_q;
    unique case (req_i.op)
      OP_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_d = ST_BADPOS;
        end else if (count_q == CapCnt) begin
          status_d = ST_FULL;
        end else begin
          act_d   = ACT_INSERT;
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          status_d = ST_BADPOS;
        end else begin
          act_d   = ACT_DELETE;
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_SET: begin
        if (pos_ext >= cnt_ext) status_d = ST_BADPOS;
        else                    act_d    = ACT_SET;
      end
      OP_GET: begin
        if (pos_ext >= cnt_ext) status_d = ST_BADPOS;
        else                    act_d    = ACT_GET;
      end
      OP_LOCATE: begin
        // an empty list simply never hits
        act_d = ACT_LOCATE;
      end
      default: begin
        // unknown codes: no change, ok status
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      status_q     <= ST_OK;
      head_ctl_q   <= '{valid: 1'b0, act: ACT_NONE, hit: 1'b0};
      head_pos_q   <= '0;
      head_cnt_q   <= '0;
      head_val_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_data_q   <= '0;
      out_fidx_q   <= '0;
      out_count_q  <= '0;
    end else begin
      if (req_fire) begin
        state_q    <= S_BUSY;
        count_q    <= count_d;
        status_q   <= status_d;
        head_ctl_q <= '{valid: 1'b1, act: act_d, hit: 1'b0};
        // a legal position always fits the index width
        head_pos_q <= IDX_W'(req_i.position);
        head_cnt_q <= count_q;
        head_val_q <= DATA_WIDTH'(req_i.value);
      end else begin
        head_ctl_q.valid <= 1'b0;
      end
      if (tail_ctl.valid) begin
        state_q     <= S_IDLE;
        out_valid_q <= 1'b1;
        if (tail_ctl.act == ACT_LOCATE) begin
          out_status_q <= tail_ctl.hit ? ST_OK : ST_MISS;
        end else begin
          out_status_q <= status_q;
        end
        if ((tail_ctl.act == ACT_DELETE) || (tail_ctl.act == ACT_GET)) begin
          out_data_q <= 32'($signed(tail_carry));
        end else begin
          out_data_q <= '0;
        end
        out_fidx_q  <= 6'(tail_fidx);
        out_count_q <= 7'(count_q);
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // row of cells; cell 0 is fed from the head register
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    probe_ctl_t            in_ctl;
    logic [IDX_W-1:0]      in_pos;
    logic [CNT_W-1:0]      in_cnt;
    logic [DATA_WIDTH-1:0] in_val, in_carry, in_bk_data;
    logic [IDX_W-1:0]      in_fidx;
    logic                  in_bk_valid;

    if (i == 0) begin : g_first
      assign in_ctl   = head_ctl_q;
      assign in_pos   = head_pos_q;
      assign in_cnt   = head_cnt_q;
      assign in_val   = head_val_q;
      assign in_carry = '0;
      assign in_fidx  = '0;
    end else begin : g_next
      assign in_ctl   = ch_ctl[i-1];
      assign in_pos   = ch_pos[i-1];
      assign in_cnt   = ch_cnt[i-1];
      assign in_val   = ch_val[i-1];
      assign in_carry = ch_carry[i-1];
      assign in_fidx  = ch_fidx[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign in_bk_valid = 1'b0;
      assign in_bk_data  = '0;
    end else begin : g_mid
      assign in_bk_valid = bk_valid[i+1];
      assign in_bk_data  = bk_data[i+1];
    end

    ple_cell #(
      .IDX        (i),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (in_ctl),
      .pos_i      (in_pos),
      .cnt_i      (in_cnt),
      .val_i      (in_val),
      .carry_i    (in_carry),
      .fidx_i     (in_fidx),
      .ctl_o      (ch_ctl[i]),
      .pos_o      (ch_pos[i]),
      .cnt_o      (ch_cnt[i]),
      .val_o      (ch_val[i]),
      .carry_o    (ch_carry[i]),
      .fidx_o     (ch_fidx[i]),
      .bk_valid_i (in_bk_valid),
      .bk_data_i  (in_bk_data),
      .bk_valid_o (bk_valid[i]),
      .bk_data_o  (bk_data[i])
    );
  end

  assign tail_ctl   = ch_ctl[CAPACITY-1];
  assign tail_carry = ch_carry[CAPACITY-1];
  assign tail_fidx  = ch_fidx[CAPACITY-1];

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.data_out    = out_data_q;
  assign rsp_o.found_index = out_fidx_q;
  assign rsp_o.count       = out_count_q;

  // no new transfer while a probe is in the chain
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BUSY) |-> !req_fire)
    else $error("request taken while a probe is in flight");

  // a probe only leaves the chain while busy
  a_tail_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_ctl.valid |-> (state_q == S_BUSY))
    else $error("probe left the chain with no request in flight");

  // a probe never lands on a result that is still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_ctl.valid |-> (!out_valid_q || rsp_o.ready))
    else $error("result register overrun");

  // count moves only on a transfer and stays within capacity
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_fire |=> $stable(count_q))
    else $error("count changed without a request");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("count above capacity");

endmodule

/* tb/ple_result_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_result_check
// Watches both channels of the list engine and keeps a shadow copy of the
// list. Every request transfer is applied to the shadow list and its result
// is queued. Every response transfer is compared, field by field, with the
// oldest queued result. Failures are counted and handed to the bench top.
// ----------------------------------------------------------------------------
module ple_result_check
  import ple_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ple_req_if   req_i,
  ple_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   list_len_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [5:0]  found;
    logic [6:0]  count;
  } list_result_t;

  logic [31:0]  list_cells [DefCapacity];
  int unsigned  cell_count;
  list_result_t awaited_results [$];

  // Apply one operation to the shadow list and build the result it yields.
  task automatic apply_list_op(input logic [2:0] op, input logic [6:0] pos,
                               input logic [31:0] val, output list_result_t res);
    res        = '0;
    res.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (pos > cell_count) begin
          res.status = ST_BADPOS;
        end else if (cell_count >= DefCapacity) begin
          res.status = ST_FULL;
        end else begin
          for (int j = cell_count; j > pos; j--) list_cells[j] = list_cells[j-1];
          list_cells[pos] = val;
          cell_count++;
        end
      end
      OP_DELETE: begin
        if (pos >= cell_count) begin
          res.status = ST_BADPOS;
        end else begin
          res.data = list_cells[pos];
          for (int j = pos; j + 1 < cell_count; j++) list_cells[j] = list_cells[j+1];
          cell_count--;
        end
      end
      OP_SET: begin
        if (pos >= cell_count) res.status = ST_BADPOS;
        else list_cells[pos] = val;
      end
      OP_GET: begin
        if (pos >= cell_count) res.status = ST_BADPOS;
        else res.data = list_cells[pos];
      end
      OP_LOCATE: begin
        // scan downward so the last hit seen is the lowest index
        res.status = ST_MISS;
        for (int j = cell_count - 1; j >= 0; j--) begin
          if (list_cells[j] == val) begin
            res.status = ST_OK;
            res.found  = 6'(j);
          end
        end
      end
      default: ;
    endcase
    res.count = 7'(cell_count);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    if (!rst_ni) begin
      cell_count = 0;
      awaited_results.delete();
      fail_count_o = 0;
    end else begin
      // response first: its expectation always predates a same-edge request
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t ns: response with none expected, status %0d data 0x%0h",
                   $time, rsp_i.status, rsp_i.data_out);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_i.status));
          check_field("data_out", want.data, rsp_i.data_out);
          check_field("found_index", 32'(want.found), 32'(rsp_i.found_index));
          check_field("count", 32'(want.count), 32'(rsp_i.count));
        end
      end
      if (req_i.valid && req_i.ready) begin
        apply_list_op(req_i.op, req_i.position, req_i.value, want);
        awaited_results.push_back(want);
      end
    end
    pending_o  = awaited_results.size();
    list_len_o = cell_count;
  end

endmodule

/* tb/positional_list_engine_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_core_tb
// Stimulus and verdict for the positional list engine.
// A directed opening walks the empty list, the field extremes, duplicate
// values, every operation and unused op codes. Random traffic follows in
// phases that grow, shrink or churn the list, so it runs empty and full
// many times. Checking is done by ple_result_check.
// ----------------------------------------------------------------------------
module positional_list_engine_core_tb;
  import ple_pkg::*;

  localparam int unsigned RandomItems   = 1630;
  // no transfer on either channel for this long means the block is hung;
  // a correct run stays below it: its longest idle stretch is latency + stall + gap
  localparam int unsigned IdleLimit     = 2000;
  // after the last result, wait beyond the depth of one request before the verdict
  localparam int unsigned DrainCycles   = DefCapacity + 40;
  localparam int unsigned PoolSize      = 12;
  localparam logic [2:0]  OpFirstUnused = 3'd5;
  localparam logic [2:0]  OpLastUnused  = 3'd7;

  // traffic mix of one random phase
  typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_e;
  // response-side stall behavior
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_BURSTY} rdy_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int fail_count;
  int pending_results;
  int list_len;
  int idle_cycles = 0;

  // sender burst state
  int burst_left = 0;
  int gap_len;

  // receiver stall state
  rdy_mode_e rdy_mode      = RDY_ALWAYS;
  int        rdy_mode_left = 0;
  int        run_left      = 0;
  logic      run_high      = 1'b1;

  logic [31:0] value_pool [PoolSize];

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  ple_result_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending_results),
    .list_len_o   (list_len)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge. Phases of always-ready, a
  // coin flip per cycle, or long stall runs with short open windows, so stalls
  // hit the output register at every point.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rdy_mode_left == 0) begin
      rdy_mode      = rdy_mode_e'($urandom_range(0, 2));
      rdy_mode_left = $urandom_range(50, 400);
    end else begin
      rdy_mode_left--;
    end
    case (rdy_mode)
      RDY_ALWAYS: rsp_ch.ready <= 1'b1;
      RDY_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (run_left == 0) begin
          run_high = !run_high;
          run_left = run_high ? $urandom_range(1, 4) : $urandom_range(1, 40);
        end else begin
          run_left--;
        end
        rsp_ch.ready <= run_high;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles with no transfer on either channel.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t ns: timeout, no transfer for %0d cycles, %0d results outstanding",
                 $time, IdleLimit, pending_results);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: called at a falling edge, returns at the falling edge after the
  // transfer. Valid stays high between back-to-back calls; a new burst may
  // start with a gap (mostly short, sometimes longer than the block's
  // latency so the gap lands on every phase of the walk).
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [2:0] op, input logic [6:0] pos,
                          input logic [31:0] val);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_len    = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 90)
                                               : $urandom_range(0, 6);
      if (gap_len > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap_len) @(negedge clk_i);
      end
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.position <= pos;
    req_ch.value    <= val;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Position picker: mostly legal for the op, with the ends of the list
  // favored, plus a share of arbitrary positions across the whole field.
  function automatic logic [6:0] pick_pos(input logic [2:0] op, input int len);
    int r;
    int lim;
    r   = $urandom_range(0, 99);
    lim = (op == OP_INSERT) ? len : len - 1;
    if (r < 8)   return 7'($urandom_range(0, 127));
    if (r < 12)  return 7'(len);   // one past the end
    if (lim < 0) return 7'd0;      // empty list, non-insert: bad position
    if (r < 20)  return 7'd0;
    if (r < 28)  return 7'(lim);
    return 7'($urandom_range(0, lim));
  endfunction

  // Values come mostly from a small pool so locate hits and duplicates occur.
  function automatic logic [31:0] pick_value(input int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, PoolSize - 1)];
    return $urandom;
  endfunction

  initial begin
    mix_e        mix;
    int          mix_left;
    int          ins_thr;
    int          del_thr;
    int          r;
    logic [2:0]  op;

    req_ch.valid    = 1'b0;
    req_ch.op       = OP_INSERT;
    req_ch.position = '0;
    req_ch.value    = '0;
    rsp_ch.ready    = 1'b0;

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < PoolSize; i++) value_pool[i] = $urandom;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---- directed: empty list ----
    send_req(OP_LOCATE, 7'd0, 32'h0);            // empty list always misses
    send_req(OP_GET,    7'd0, 32'h0);            // bad position on empty list
    send_req(OP_DELETE, 7'd0, 32'h0);
    send_req(OP_SET,    7'd0, 32'h1);
    send_req(OP_INSERT, 7'd1, 32'h5);            // insert above count
    // ---- build [-1, min, max, max, 0] ----
    send_req(OP_INSERT, 7'd0, 32'h8000_0000);
    send_req(OP_INSERT, 7'd1, 32'h7FFF_FFFF);    // append at count
    send_req(OP_INSERT, 7'd0, 32'hFFFF_FFFF);    // shift everything up
    send_req(OP_INSERT, 7'd3, 32'h0000_0000);
    send_req(OP_INSERT, 7'd127, 32'h0000_0000);  // top position, bad
    send_req(OP_INSERT, 7'd2, 32'h7FFF_FFFF);    // duplicate value
    // ---- reads and searches ----
    send_req(OP_LOCATE, 7'd0, 32'h7FFF_FFFF);    // lowest of two matches
    send_req(OP_LOCATE, 7'd127, 32'h0000_0000);  // position is don't-care
    send_req(OP_LOCATE, 7'd0, 32'h1234_5678);    // miss on non-empty list
    send_req(OP_GET,    7'd1, 32'h0);            // most negative value
    send_req(OP_GET,    7'd5, 32'h0);            // position equal to count
    send_req(OP_SET,    7'd4, 32'hAAAA_5555);
    send_req(OP_SET,    7'd127, 32'h5555_AAAA);
    // ---- removals ----
    send_req(OP_DELETE, 7'd0, 32'h0);            // head, shift down
    send_req(OP_DELETE, 7'd3, 32'h0);            // tail
    send_req(OP_DELETE, 7'd3, 32'h0);            // now equal to count
    // ---- unused op codes change nothing ----
    for (int c = OpFirstUnused; c <= OpLastUnused; c++)
      send_req(3'(c), 7'd127, 32'hFFFF_FFFF);

    // ---- random: phases that fill, drain or churn the list ----
    mix_left = 0;
    repeat (RandomItems) begin
      if (mix_left == 0) begin
        mix      = mix_e'($urandom_range(0, 2));
        mix_left = $urandom_range(60, 200);
      end
      mix_left--;
      case (mix)
        MIX_GROW:   begin ins_thr = 70; del_thr = 75; end
        MIX_SHRINK: begin ins_thr = 8;  del_thr = 70; end
        default:    begin ins_thr = 35; del_thr = 62; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_thr) begin
        op = OP_INSERT;
      end else if (r < del_thr) begin
        op = OP_DELETE;
      end else if (r < 97) begin
        case ($urandom_range(0, 2))
          0:       op = OP_SET;
          1:       op = OP_GET;
          default: op = OP_LOCATE;
        endcase
      end else begin
        op = 3'($urandom_range(OpFirstUnused, OpLastUnused));
      end
      send_req(op, pick_pos(op, list_len), pick_value(op == OP_LOCATE ? 85 : 55));
    end
    req_ch.valid <= 1'b0;

    // ---- drain and verdict ----
    while (pending_results != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
